[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: record layout,
// request kinds, result status codes and stream widths.
// ----------------------------------------------------------------------------
package spq_pkg;

    // default number of stored records
    localparam int DEPTH_DEFAULT = 16;

    // field widths
    localparam int PID_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int OCC_W   = 5;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // request kinds
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // one stored record
    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } rec_t;

endpackage

[rtl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue of process records kept in ascending priority order,
// equal priorities in arrival order. Records live in a circular memory with
// one read and one write port; inserts walk from the tail toward the head,
// moving entries.
// ----------------------------------------------------------------------------
//
// channel   dir  tdata (low bit up)                          tuser
// s_axis    in   process_id, burst_time, priority_req        kind
// m_axis    out  out_process_id, out_burst_time,             status
//                out_priority, occupancy, zero pad
//
// A dequeue reads the front record, then advances the head and passes the
// result on; an empty dequeue or a refused enqueue goes straight to the
// result. An enqueue into an empty queue writes slot zero at once; otherwise
// it walks the entry memory from the tail toward the head, one read and one
// write a cycle, moving up each stored record that sorts behind the new one.
// One request is worked at a time; s_axis_tready is low while busy and while
// a finished result waits for the output register to free up. Reset clears
// the count and the head pointer; memory contents need no clearing.
//
module stable_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // process_id [15:0], burst_time [31:16], priority_req [39:32]
    input  logic [spq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // kind [0]
    input  logic [spq_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_process_id [15:0], out_burst_time [31:16], out_priority [39:32],
    // occupancy [44:40], zero [47:45]
    output logic [spq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [spq_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    import spq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_SCAN,
        S_ENQ_CMP,
        S_DEQ_WAIT,
        S_DONE
    } state_t;

    // logical slot to physical memory address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] slot);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, slot};
        if (sum >= (AW+1)'(DEPTH))
        begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // entry memory
    rec_t mem [DEPTH];
    rec_t rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    rec_t          mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    state_t        state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    rec_t          new_reg, new_next;
    status_t       res_status_reg, res_status_next;
    rec_t          res_rec_reg, res_rec_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    rec_t          out_rec_reg, out_rec_next;
    logic [OCC_W-1:0] out_occ_reg, out_occ_next;
    logic [31:0]   count_ext;

    // memory write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    // memory read port, registered data
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data <= mem[mem_ra];
        end
    end

    assign count_ext = 32'(count_reg);

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_occ_next    = out_occ_reg;
        mem_we          = 1'b0;
        mem_wa          = phys(head_reg, idx_reg);
        mem_wd          = new_reg;
        mem_re          = 1'b0;
        mem_ra          = head_reg;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    new_next.pid   = s_axis_tdata[15:0];
                    new_next.burst = s_axis_tdata[31:16];
                    new_next.prio  = s_axis_tdata[39:32];
                    res_rec_next   = '0;
                    if (s_axis_tuser[0] == KIND_ENQ)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg[AW-1:0];
                            state_next = S_ENQ_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = head_reg;
                            state_next = S_DEQ_WAIT;
                        end
                    end
                end
            end

            // slot zero takes the new record, else fetch the neighbor below
            S_ENQ_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    mem_we          = 1'b1;
                    mem_wa          = phys(head_reg, idx_reg);
                    mem_wd          = new_reg;
                    count_next      = count_reg + CW'(1);
                    res_status_next = ST_ENQUEUED;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = phys(head_reg, idx_reg - AW'(1));
                    state_next = S_ENQ_CMP;
                end
            end

            // move a later-served neighbor up, or drop the new record in
            S_ENQ_CMP:
            begin
                mem_we = 1'b1;
                mem_wa = phys(head_reg, idx_reg);
                if (rd_data.prio > new_reg.prio)
                begin
                    mem_wd   = rd_data;
                    idx_next = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_ENQ_SCAN;
                    end
                    else
                    begin
                        mem_re = 1'b1;
                        mem_ra = phys(head_reg, idx_reg - AW'(1) - AW'(1));
                    end
                end
                else
                begin
                    mem_wd          = new_reg;
                    count_next      = count_reg + CW'(1);
                    res_status_next = ST_ENQUEUED;
                    state_next      = S_DONE;
                end
            end

            // front record arrives, advance head
            S_DEQ_WAIT:
            begin
                res_rec_next    = rd_data;
                res_status_next = ST_DEQUEUED;
                head_next       = phys(head_reg, AW'(1));
                count_next      = count_reg - CW'(1);
                state_next      = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_rec_next    = res_rec_reg;
                    out_occ_next    = count_ext[OCC_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            new_reg        <= '0;
            res_status_reg <= ST_ENQUEUED;
            res_rec_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_ENQUEUED;
            out_rec_reg    <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            new_reg        <= new_next;
            res_status_reg <= res_status_next;
            res_rec_reg    <= res_rec_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rec_reg    <= out_rec_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    // port drive
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_rec_reg.prio,
                            out_rec_reg.burst, out_rec_reg.pid};

endmodule
